FILE: hdl/lwbc_pkg.sv
// Package for the LRU write-back block cache tag and policy engine.
// Holds operation and result codes and default sizes; no dependencies.
`timescale 1ns / 1ps
package lwbc_pkg;
    localparam int SLOTS_DEF = 16;
    localparam int FILE_ID_BITS_DEF = 10;
    localparam int CAP_BITS = 5;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_CLOSE = 2'd3;

    localparam logic [1:0] KIND_HIT  = 2'd0;
    localparam logic [1:0] KIND_FILL = 2'd1;
    localparam logic [1:0] KIND_WB   = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;
endpackage

FILE: hdl/lru_write_back_block_cache_core.sv
// Top level of the LRU write-back block cache tag and policy engine; depends on lwbc_pkg.
// Slots are scanned one per cycle, paused while a writeback result waits in S_OUT; a miss goes
// through S_VICT, S_EVICT and S_FILL after its scan. A flush scans every rank of every slot,
// and a close then scans the slots again to drop the file's entries.
// One item at a time: the next input transfer is taken only after the last result transfer.
// Synchronous active-low reset clears valid and dirty bits, capacity to 16.
`timescale 1ns / 1ps
module lru_write_back_block_cache_core
    import lwbc_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int FILE_ID_BITS = FILE_ID_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CAP_BITS-1:0]     i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [1:0]              i_operation,
    input  logic [FILE_ID_BITS-1:0] i_file_id,
    input  logic [31:0]             i_block_number,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [1:0]              o_kind,
    output logic [3:0]              o_slot,
    output logic [FILE_ID_BITS-1:0] o_out_file_id,
    output logic [31:0]             o_out_block_number,
    output logic                    o_last
);
    localparam int SB = $clog2(SLOTS);
    localparam int CB = $clog2(SLOTS + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_MATCH = 8'b00000010,
        S_VICT  = 8'b00000100,
        S_EVICT = 8'b00001000,
        S_FILL  = 8'b00010000,
        S_FLUSH = 8'b00100000,
        S_CLOSE = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    t_state r_after;

    logic [SLOTS-1:0]        r_vld, r_dirty;
    logic [FILE_ID_BITS-1:0] r_efile [SLOTS];
    logic [31:0]             r_eblock [SLOTS];
    logic [SB-1:0]           r_rank [SLOTS];

    logic [CAP_BITS-1:0]     r_cap;
    logic [1:0]              r_op;
    logic [FILE_ID_BITS-1:0] r_file;
    logic [31:0]             r_block;
    logic [SB-1:0]           r_idx;
    logic [SB:0]             r_rk;
    logic                    r_vic_ok;
    logic [SB-1:0]           r_vic;
    logic [SB-1:0]           r_vrank;
    logic                    r_free_ok;
    logic [SB-1:0]           r_free;
    logic [CB-1:0]           r_cnt;

    logic                    r_ov;
    logic [1:0]              r_ok;
    logic [SB-1:0]           r_os;
    logic [FILE_ID_BITS-1:0] r_of;
    logic [31:0]             r_ob;
    logic                    r_ol;

    // Effective capacity, clamped into 1..SLOTS.
    logic [CB:0] w_cap;
    always_comb begin
        if (r_cap == '0) begin
            w_cap = (CB+1)'(1);
        end else if ({{(CB+1){1'b0}}, r_cap} > (CB+1+CAP_BITS)'(SLOTS)) begin
            w_cap = (CB+1)'(SLOTS);
        end else begin
            w_cap = (CB+1)'(r_cap);
        end
    end

    logic w_last_idx;
    assign w_last_idx = (r_idx == SB'(SLOTS - 1));

    // Shared slot compare on the scan index.
    logic w_fmatch, w_match;
    assign w_fmatch = r_vld[r_idx] && (r_efile[r_idx] == r_file);
    assign w_match  = w_fmatch && (r_eblock[r_idx] == r_block);

    // Flush scan: a dirty entry of the file at the current rank, and the last scan step.
    logic w_flush_wb, w_scan_end;
    assign w_flush_wb = w_fmatch && r_dirty[r_idx] && ({1'b0, r_rank[r_idx]} == r_rk);
    assign w_scan_end = w_last_idx && (r_rk == (SB+1)'(SLOTS - 1));

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ov;
    assign o_kind = r_ok;
    assign o_slot = 4'(r_os);
    assign o_out_file_id = r_of;
    assign o_out_block_number = r_ob;
    assign o_last = r_ol;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = i_valid ? ((i_operation == OP_READ || i_operation == OP_WRITE)
                                          ? S_MATCH : S_FLUSH) : S_IDLE;
            S_MATCH: n_state = (w_match) ? S_OUT : (w_last_idx ? S_VICT : S_MATCH);
            S_VICT:  n_state = S_EVICT;
            S_EVICT: n_state = S_FILL;
            S_FILL:  n_state = S_OUT;
            S_FLUSH: n_state = S_FLUSH;
            S_CLOSE: n_state = S_CLOSE;
            S_OUT:   n_state = S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer and state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= S_IDLE;
            r_vld <= '0;
            r_dirty <= '0;
            r_cap <= CAP_BITS'(16);
            r_ov <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op <= i_operation;
                        r_file <= i_file_id;
                        r_block <= i_block_number;
                        r_idx <= '0;
                        r_rk <= '0;
                        r_cnt <= '0;
                        r_vic_ok <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_state <= n_state;
                    end
                end
                S_MATCH: begin
                    // One slot per cycle: match, count, victim, first free slot.
                    if (r_vld[r_idx]) begin
                        r_cnt <= r_cnt + CB'(1);
                        if (!r_vic_ok || r_rank[r_idx] > r_vrank) begin
                            r_vic_ok <= 1'b1;
                            r_vic <= r_idx;
                            r_vrank <= r_rank[r_idx];
                        end
                    end else if (!r_free_ok) begin
                        r_free_ok <= 1'b1;
                        r_free <= r_idx;
                    end
                    if (w_match) begin
                        // Hit: make most recent.
                        for (int i = 0; i < SLOTS; i++) begin
                            if (r_vld[i] && SB'(i) != r_idx && r_rank[i] < r_rank[r_idx]) begin
                                r_rank[i] <= r_rank[i] + SB'(1);
                            end
                        end
                        r_rank[r_idx] <= '0;
                        if (r_op == OP_WRITE) begin
                            r_dirty[r_idx] <= 1'b1;
                        end
                        r_ov <= 1'b1;
                        r_ok <= KIND_HIT;
                        r_os <= r_idx;
                        r_of <= r_file;
                        r_ob <= r_block;
                        r_ol <= 1'b1;
                        r_after <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + SB'(1);
                    end
                    r_state <= n_state;
                end
                S_VICT: begin
                    // Evict least recent entry when full.
                    if ({1'b0, r_cnt} >= w_cap && r_vic_ok) begin
                        r_vld[r_vic] <= 1'b0;
                        r_dirty[r_vic] <= 1'b0;
                        for (int i = 0; i < SLOTS; i++) begin
                            if (r_vld[i] && r_rank[i] > r_vrank) begin
                                r_rank[i] <= r_rank[i] - SB'(1);
                            end
                        end
                        if (!r_free_ok || r_vic < r_free) begin
                            r_free_ok <= 1'b1;
                            r_free <= r_vic;
                        end
                        if (r_dirty[r_vic]) begin
                            r_ov <= 1'b1;
                            r_ok <= KIND_WB;
                            r_os <= r_vic;
                            r_of <= r_efile[r_vic];
                            r_ob <= r_eblock[r_vic];
                            r_ol <= 1'b0;
                            r_after <= S_EVICT;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_EVICT;
                        end
                    end else begin
                        r_state <= S_EVICT;
                    end
                end
                S_EVICT: begin
                    // Insert into free slot as most recent.
                    for (int i = 0; i < SLOTS; i++) begin
                        if (r_vld[i]) begin
                            r_rank[i] <= r_rank[i] + SB'(1);
                        end
                    end
                    r_vld[r_free] <= 1'b1;
                    r_dirty[r_free] <= (r_op == OP_WRITE);
                    r_efile[r_free] <= r_file;
                    r_eblock[r_free] <= r_block;
                    r_rank[r_free] <= '0;
                    r_state <= S_FILL;
                end
                S_FILL: begin
                    // Fill result for an access, done result for a flush or close.
                    r_ov <= 1'b1;
                    r_of <= r_file;
                    r_ol <= 1'b1;
                    r_after <= S_IDLE;
                    r_state <= S_OUT;
                    if (r_op == OP_FLUSH || r_op == OP_CLOSE) begin
                        r_ok <= KIND_DONE;
                        r_os <= '0;
                        r_ob <= '0;
                    end else begin
                        r_ok <= KIND_FILL;
                        r_os <= r_free;
                        r_ob <= r_block;
                    end
                end
                S_FLUSH: begin
                    // Scan by rank, then by slot; write back dirty entries of the file.
                    if (w_flush_wb) begin
                        r_dirty[r_idx] <= 1'b0;
                        r_ov <= 1'b1;
                        r_ok <= KIND_WB;
                        r_os <= r_idx;
                        r_of <= r_file;
                        r_ob <= r_eblock[r_idx];
                        r_ol <= 1'b0;
                        r_after <= w_scan_end ? ((r_op == OP_CLOSE) ? S_CLOSE : S_FILL)
                                              : S_FLUSH;
                        r_state <= S_OUT;
                    end else if (w_scan_end) begin
                        r_state <= (r_op == OP_CLOSE) ? S_CLOSE : S_FILL;
                    end
                    if (w_last_idx) begin
                        r_idx <= '0;
                        r_rk <= r_rk + (SB+1)'(1);
                    end else begin
                        r_idx <= r_idx + SB'(1);
                    end
                end
                S_CLOSE: begin
                    // Drop the file's entries one slot per cycle.
                    if (w_fmatch) begin
                        r_vld[r_idx] <= 1'b0;
                        r_dirty[r_idx] <= 1'b0;
                        for (int i = 0; i < SLOTS; i++) begin
                            if (r_vld[i] && r_rank[i] > r_rank[r_idx]) begin
                                r_rank[i] <= r_rank[i] - SB'(1);
                            end
                        end
                    end
                    if (w_last_idx) begin
                        r_op <= OP_FLUSH;
                        r_state <= S_FILL;
                    end
                    r_idx <= r_idx + SB'(1);
                end
                S_OUT: begin
                    if (!r_ov || i_ready) begin
                        r_state <= r_after;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: tb/lru_write_back_block_cache_core_tb.sv
// Self-checking testbench for the LRU write-back block cache tag and policy engine.
// Holds its own cache predictor, a queued driver and a checking monitor.
// Depends on lwbc_pkg and lru_write_back_block_cache_core.
`timescale 1ns / 1ps
module lru_write_back_block_cache_core_tb;
    import lwbc_pkg::*;

    localparam int NSLOT = 16;
    localparam int SETTLE_CYCLES = NSLOT * NSLOT + 40;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  fid;
        logic [31:0] blk;
    } t_access;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [9:0]  fid;
        logic [31:0] blk;
        logic        last;
    } t_cache_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [4:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_operation = OP_READ;
    logic [9:0]  i_file_id = '0;
    logic [31:0] i_block_number = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [3:0]  o_slot;
    logic [9:0]  o_out_file_id;
    logic [31:0] o_out_block_number;
    logic        o_last;

    // Predictor state: tags, dirty bits, recency ranks and the capacity register.
    logic        ent_valid [NSLOT];
    logic        ent_dirty [NSLOT];
    logic [9:0]  ent_fid [NSLOT];
    logic [31:0] ent_blk [NSLOT];
    int          ent_rank [NSLOT];
    logic [4:0]  capacity_reg = 5'd16;

    t_access       access_q [$];
    t_cache_result result_q [$];
    int            err_cnt = 0;
    int            send_idle_pct = 0;
    int            stall_pct = 0;
    logic          in_fire = 1'b0;
    int            quiet_cycles = 0;

    lru_write_back_block_cache_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_operation(i_operation), .i_file_id(i_file_id), .i_block_number(i_block_number),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_kind(o_kind), .o_slot(o_slot), .o_out_file_id(o_out_file_id),
        .o_out_block_number(o_out_block_number), .o_last(o_last)
    );

    always #2 i_clk = ~i_clk;

    function automatic void push_result(logic [1:0] k, int s, logic [9:0] f,
                                        logic [31:0] b, logic l);
        t_cache_result r;
        r.kind = k;
        r.slot = s[3:0];
        r.fid = f;
        r.blk = b;
        r.last = l;
        result_q.push_back(r);
    endfunction

    // Remove a slot and close the gap in the recency order.
    function automatic void evict_slot(int s);
        ent_valid[s] = 1'b0;
        ent_dirty[s] = 1'b0;
        for (int i = 0; i < NSLOT; i++)
            if (ent_valid[i] && ent_rank[i] > ent_rank[s]) ent_rank[i]--;
    endfunction

    // Work out the results that one accepted item causes and update the cache image.
    function automatic void predict_cache(t_access a);
        int cnt;
        int lim;
        int victim;
        int free_slot;
        int r0;
        cnt = 0;
        victim = -1;
        free_slot = 0;
        if (a.op == OP_READ || a.op == OP_WRITE) begin
            for (int i = 0; i < NSLOT; i++) begin
                if (ent_valid[i] && ent_fid[i] == a.fid && ent_blk[i] == a.blk) begin
                    r0 = ent_rank[i];
                    for (int j = 0; j < NSLOT; j++)
                        if (ent_valid[j] && j != i && ent_rank[j] < r0) ent_rank[j]++;
                    ent_rank[i] = 0;
                    if (a.op == OP_WRITE) ent_dirty[i] = 1'b1;
                    push_result(KIND_HIT, i, a.fid, a.blk, 1'b1);
                    return;
                end
            end
            for (int i = 0; i < NSLOT; i++) if (ent_valid[i]) cnt++;
            lim = (capacity_reg == 0) ? 1 : (capacity_reg > NSLOT) ? NSLOT : capacity_reg;
            if (cnt >= lim) begin
                for (int i = 0; i < NSLOT; i++)
                    if (ent_valid[i] && (victim < 0 || ent_rank[i] > ent_rank[victim]))
                        victim = i;
                if (victim >= 0) begin
                    if (ent_dirty[victim])
                        push_result(KIND_WB, victim, ent_fid[victim], ent_blk[victim], 1'b0);
                    evict_slot(victim);
                end
            end
            for (int i = NSLOT - 1; i >= 0; i--) if (!ent_valid[i]) free_slot = i;
            for (int i = 0; i < NSLOT; i++) if (ent_valid[i]) ent_rank[i]++;
            ent_valid[free_slot] = 1'b1;
            ent_dirty[free_slot] = (a.op == OP_WRITE);
            ent_fid[free_slot] = a.fid;
            ent_blk[free_slot] = a.blk;
            ent_rank[free_slot] = 0;
            push_result(KIND_FILL, free_slot, a.fid, a.blk, 1'b1);
        end else begin
            // Dirty blocks of the file go out from most recent to least recent.
            for (int r = 0; r < NSLOT; r++)
                for (int i = 0; i < NSLOT; i++)
                    if (ent_valid[i] && ent_rank[i] == r && ent_fid[i] == a.fid
                        && ent_dirty[i]) begin
                        push_result(KIND_WB, i, a.fid, ent_blk[i], 1'b0);
                        ent_dirty[i] = 1'b0;
                    end
            if (a.op == OP_CLOSE)
                for (int i = 0; i < NSLOT; i++)
                    if (ent_valid[i] && ent_fid[i] == a.fid) evict_slot(i);
            push_result(KIND_DONE, 0, a.fid, 32'd0, 1'b1);
        end
    endfunction

    function automatic void add_access(logic [1:0] op, logic [9:0] f, logic [31:0] b);
        t_access a;
        a.op = op;
        a.fid = f;
        a.blk = b;
        access_q.push_back(a);
    endfunction

    // Random traffic: mostly accesses over a small working set, some flushes and closes.
    function automatic void add_random(int n);
        logic [1:0]  op;
        logic [9:0]  f;
        logic [31:0] b;
        int          pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            op = (pick < 45) ? OP_READ : (pick < 85) ? OP_WRITE :
                 (pick < 93) ? OP_FLUSH : OP_CLOSE;
            f = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(3));
            b = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(11));
            if ($urandom_range(19) == 0) b = ~b;
            add_access(op, f, b);
        end
    endfunction

    // Drive the input channel; a pending item holds until its transfer.
    always @(posedge i_clk) in_fire <= i_valid && o_ready;

    always @(negedge i_clk) begin
        t_access a;
        if (i_rst_n) begin
            i_ready <= ($urandom_range(99) >= stall_pct);
            if (!i_valid || in_fire) begin
                if (access_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    a = access_q.pop_front();
                    i_operation <= a.op;
                    i_file_id <= a.fid;
                    i_block_number <= a.blk;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Predict on each input transfer and check each output transfer.
    always @(posedge i_clk) begin
        t_access       a;
        t_cache_result e;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                a.op = i_operation;
                a.fid = i_file_id;
                a.blk = i_block_number;
                predict_cache(a);
            end
            if (o_valid && i_ready) begin
                if (result_q.size() == 0) begin
                    $error("unexpected result kind=%0d slot=%0d", o_kind, o_slot);
                    err_cnt++;
                end else begin
                    e = result_q.pop_front();
                    if (o_kind !== e.kind) begin
                        $error("kind: expected %0d, got %0d", e.kind, o_kind);
                        err_cnt++;
                    end
                    if (o_slot !== e.slot) begin
                        $error("slot: expected %0d, got %0d", e.slot, o_slot);
                        err_cnt++;
                    end
                    if (o_out_file_id !== e.fid) begin
                        $error("out_file_id: expected %0d, got %0d", e.fid, o_out_file_id);
                        err_cnt++;
                    end
                    if (o_out_block_number !== e.blk) begin
                        $error("out_block_number: expected %h, got %h", e.blk,
                               o_out_block_number);
                        err_cnt++;
                    end
                    if (o_last !== e.last) begin
                        $error("last: expected %0d, got %0d", e.last, o_last);
                        err_cnt++;
                    end
                end
            end
            // Watchdog on cycles without any transfer.
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic write_capacity(logic [4:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        capacity_reg = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain_and_settle();
        while (access_q.size() > 0 || i_valid || result_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [4:0] cap, int n, int sp, int rp);
        write_capacity(cap);
        send_idle_pct = sp;
        stall_pct = rp;
        add_random(n);
        drain_and_settle();
    endtask

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            ent_valid[i] = 1'b0;
            ent_dirty[i] = 1'b0;
            ent_rank[i] = 0;
        end
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: hits, extremes, empty flush, a full cache with dirty eviction, close.
        add_access(OP_WRITE, 10'd0, 32'd0);
        add_access(OP_READ, 10'd0, 32'd0);
        add_access(OP_READ, 10'h3FF, 32'hFFFF_FFFF);
        add_access(OP_WRITE, 10'h3FF, 32'hFFFF_FFFF);
        add_access(OP_FLUSH, 10'h3FF, 32'hFFFF_FFFF);
        add_access(OP_FLUSH, 10'd7, 32'd0);
        for (int k = 1; k <= 14; k++) add_access(OP_WRITE, 10'd3, 32'(k));
        add_access(OP_WRITE, 10'd3, 32'd15);
        add_access(OP_READ, 10'd3, 32'd5);
        add_access(OP_CLOSE, 10'd3, 32'd0);
        add_access(OP_CLOSE, 10'd0, 32'd0);
        drain_and_settle();

        // Random phases over capacities, including both extremes and out-of-range values.
        run_phase(5'd16, 70, 0, 0);
        run_phase(5'd2, 65, 78, 0);
        run_phase(5'd0, 60, 0, 78);
        run_phase(5'd31, 70, 37, 37);
        run_phase(5'd9, 70, 0, 0);
        run_phase(5'd1, 60, 78, 78);
        run_phase(5'd5, 70, 37, 37);

        if (err_cnt == 0 && result_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
